// ===== hw/rtl/psd_pkg.sv =====
// Shared types and constants for the point-to-segment squared distance pipeline.
package psd_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int NUM_W      = 100;
  localparam int QUO_W      = 50;
  localparam int SQ_W       = 52;
  localparam int PAR_W      = 17;
  localparam int DIV_STAGES = QUO_W;
  localparam logic [PAR_W-1:0] PARAM_ONE = 17'h10000;

  typedef struct packed {
    logic [1:0]                   dimension;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } psd_in_t;

  typedef struct packed {
    logic             status;
    logic [SQ_W-1:0]  distance_sq;
    logic [PAR_W-1:0] param;
    logic [SQ_W-1:0]  length_sq;
    logic [SQ_W-1:0]  from_start_sq;
  } psd_out_t;

  // How the final fields are picked once the quotients are known.
  typedef enum logic [2:0] {
    K_INVALID,
    K_AT_START,
    K_AT_END,
    K_LOW_REV,
    K_HIGH_REV,
    K_ZERO,
    K_LINE,
    K_INSIDE
  } psd_case_t;

  typedef struct packed {
    psd_case_t        kase;
    logic [QUO_W-1:0] v_sq;
    logic [QUO_W-1:0] w_sq;
    logic [QUO_W-1:0] len_sq;
  } psd_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_a;
    logic [QUO_W-1:0] den_a;
    logic [NUM_W-1:0] num_b;
    logic [QUO_W-1:0] den_b;
    psd_side_t        side;
  } psd_div_op_t;

  typedef struct packed {
    logic [QUO_W-1:0] q_a;
    logic [QUO_W-1:0] q_b;
    logic             rem_b_nz;
    psd_side_t        side;
  } psd_div_res_t;

endpackage

// ===== hw/rtl/psd_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
module psd_div import psd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  psd_div_op_t  in_op,
  output logic         out_vld,
  output psd_div_res_t out_res
);

  typedef struct packed {
    logic [QUO_W-1:0] rem;
    logic [QUO_W-1:0] nq;
    logic [QUO_W-1:0] den;
  } lane_t;

  typedef struct packed {
    lane_t     a;
    lane_t     b;
    psd_side_t side;
  } stage_t;

  // shift in the next numerator bit, subtract when it fits
  function automatic lane_t lane_step(input lane_t x);
    logic [QUO_W:0] t;
    logic [QUO_W:0] d;
    lane_t          y;
    t = {x.rem, x.nq[QUO_W-1]};
    d = {1'b0, x.den};
    y.den = x.den;
    if (t >= d) begin
      y.rem = QUO_W'(t - d);
      y.nq  = {x.nq[QUO_W-2:0], 1'b1};
    end else begin
      y.rem = t[QUO_W-1:0];
      y.nq  = {x.nq[QUO_W-2:0], 1'b0};
    end
    return y;
  endfunction

  logic   vld_r [DIV_STAGES];
  stage_t st_r  [DIV_STAGES];
  stage_t st_nxt[DIV_STAGES];
  lane_t  load_a;
  lane_t  load_b;

  always_comb begin
    load_a.rem = in_op.num_a[NUM_W-1:QUO_W];
    load_a.nq  = in_op.num_a[QUO_W-1:0];
    load_a.den = in_op.den_a;
    load_b.rem = in_op.num_b[NUM_W-1:QUO_W];
    load_b.nq  = in_op.num_b[QUO_W-1:0];
    load_b.den = in_op.den_b;
    st_nxt[0].a    = lane_step(load_a);
    st_nxt[0].b    = lane_step(load_b);
    st_nxt[0].side = in_op.side;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_nxt[k].a    = lane_step(st_r[k-1].a);
      st_nxt[k].b    = lane_step(st_r[k-1].b);
      st_nxt[k].side = st_r[k-1].side;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      st_r[k] <= st_nxt[k];
    end
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < DIV_STAGES; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign out_vld          = vld_r[DIV_STAGES-1];
  assign out_res.q_a      = st_r[DIV_STAGES-1].a.nq;
  assign out_res.q_b      = st_r[DIV_STAGES-1].b.nq;
  assign out_res.rem_b_nz = |st_r[DIV_STAGES-1].b.rem;
  assign out_res.side     = st_r[DIV_STAGES-1].side;

endmodule

// ===== hw/rtl/point_segment_distance_sq.sv =====
// Top level of the point-to-segment squared distance pipeline.
//
// Takes one query per clock (start high, busy is always low) and returns each result
// as a one-cycle out_valid strobe; results leave in the order queries arrived and
// cannot be held off. The path runs through five front stages (differences, products,
// sums, case selection with partial products of the squared dot product, divider
// operands), then the two-lane divider with 50 stages, one quotient bit each, and one
// output register. The squared distance inside the segment uses
// |v|^2 - ceil(dot^2/len), which equals the squared cross product over the length.
module point_segment_distance_sq import psd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  psd_in_t  in_item,
  output logic     out_valid,
  output psd_out_t out_item
);

  // Never stall: every beat is taken.
  assign busy = 1'b0;

  // ---- stage 1: differences and the 1D ordering
  logic                     s1_vld_r;
  logic [1:0]               s1_dim_r;
  logic signed [DIFF_W-1:0] s1_s_r [3];
  logic signed [DIFF_W-1:0] s1_v_r [3];
  logic signed [DIFF_W-1:0] s1_w_r [3];
  psd_case_t                s1_kase_r;
  logic [DIFF_W-1:0]        s1_line_r;
  logic [DIFF_W-1:0]        s1_span_r;

  logic signed [DIFF_W-1:0] a_c [3];
  logic signed [DIFF_W-1:0] b_c [3];
  logic signed [DIFF_W-1:0] p_c [3];
  logic                     rev_c;
  logic signed [DIFF_W-1:0] lo_c;
  logic signed [DIFF_W-1:0] hi_c;
  psd_case_t                kase1_nxt;

  always_comb begin
    a_c[0] = DIFF_W'(in_item.start_x);
    b_c[0] = DIFF_W'(in_item.end_x);
    p_c[0] = DIFF_W'(in_item.point_x);
    a_c[1] = in_item.dimension[1] ? DIFF_W'(in_item.start_y) : '0;
    b_c[1] = in_item.dimension[1] ? DIFF_W'(in_item.end_y) : '0;
    p_c[1] = in_item.dimension[1] ? DIFF_W'(in_item.point_y) : '0;
    a_c[2] = (&in_item.dimension) ? DIFF_W'(in_item.start_z) : '0;
    b_c[2] = (&in_item.dimension) ? DIFF_W'(in_item.end_z) : '0;
    p_c[2] = (&in_item.dimension) ? DIFF_W'(in_item.point_z) : '0;
    rev_c = a_c[0] > b_c[0];
    lo_c  = rev_c ? b_c[0] : a_c[0];
    hi_c  = rev_c ? a_c[0] : b_c[0];
    if (p_c[0] < lo_c) begin
      kase1_nxt = rev_c ? K_LOW_REV : K_AT_START;
    end else if (p_c[0] > hi_c) begin
      kase1_nxt = rev_c ? K_HIGH_REV : K_AT_END;
    end else if (hi_c == lo_c) begin
      kase1_nxt = K_ZERO;
    end else begin
      kase1_nxt = K_LINE;
    end
  end

  always_ff @(posedge clk) begin
    s1_dim_r  <= in_item.dimension;
    for (int k = 0; k < 3; k++) begin
      s1_s_r[k] <= b_c[k] - a_c[k];
      s1_v_r[k] <= p_c[k] - a_c[k];
      s1_w_r[k] <= p_c[k] - b_c[k];
    end
    s1_kase_r <= kase1_nxt;
    s1_line_r <= DIFF_W'(p_c[0] - lo_c);
    s1_span_r <= DIFF_W'(hi_c - lo_c);
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
  end

  // ---- stage 2: products
  logic                     s2_vld_r;
  logic [1:0]               s2_dim_r;
  logic signed [PROD_W-1:0] s2_sv_r [3];
  logic signed [PROD_W-1:0] s2_ss_r [3];
  logic signed [PROD_W-1:0] s2_vv_r [3];
  logic signed [PROD_W-1:0] s2_ww_r [3];
  psd_case_t                s2_kase_r;
  logic [DIFF_W-1:0]        s2_line_r;
  logic [DIFF_W-1:0]        s2_span_r;

  always_ff @(posedge clk) begin
    s2_dim_r <= s1_dim_r;
    for (int k = 0; k < 3; k++) begin
      s2_sv_r[k] <= s1_s_r[k] * s1_v_r[k];
      s2_ss_r[k] <= s1_s_r[k] * s1_s_r[k];
      s2_vv_r[k] <= s1_v_r[k] * s1_v_r[k];
      s2_ww_r[k] <= s1_w_r[k] * s1_w_r[k];
    end
    s2_kase_r <= s1_kase_r;
    s2_line_r <= s1_line_r;
    s2_span_r <= s1_span_r;
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  // ---- stage 3: sums (squares are non-negative and below 2^48)
  logic                    s3_vld_r;
  logic [1:0]              s3_dim_r;
  logic signed [DOT_W-1:0] s3_dot_r;
  logic [QUO_W-1:0]        s3_len_r;
  logic [QUO_W-1:0]        s3_vsq_r;
  logic [QUO_W-1:0]        s3_wsq_r;
  psd_case_t               s3_kase_r;
  logic [DIFF_W-1:0]       s3_line_r;
  logic [DIFF_W-1:0]       s3_span_r;

  always_ff @(posedge clk) begin
    s3_dim_r  <= s2_dim_r;
    s3_dot_r  <= DOT_W'(s2_sv_r[0]) + DOT_W'(s2_sv_r[1]) + DOT_W'(s2_sv_r[2]);
    s3_len_r  <= QUO_W'(s2_ss_r[0]) + QUO_W'(s2_ss_r[1]) + QUO_W'(s2_ss_r[2]);
    s3_vsq_r  <= QUO_W'(s2_vv_r[0]) + QUO_W'(s2_vv_r[1]) + QUO_W'(s2_vv_r[2]);
    s3_wsq_r  <= QUO_W'(s2_ww_r[0]) + QUO_W'(s2_ww_r[1]) + QUO_W'(s2_ww_r[2]);
    s3_kase_r <= s2_kase_r;
    s3_line_r <= s2_line_r;
    s3_span_r <= s2_span_r;
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  // ---- stage 4: pick the case, split dot^2 into partial products
  localparam int HALF_W = QUO_W / 2;

  logic              s4_vld_r;
  psd_case_t         s4_kase_r;
  logic [QUO_W-1:0]  s4_dotm_r;
  logic [QUO_W-1:0]  s4_hh_r;
  logic [QUO_W-1:0]  s4_hl_r;
  logic [QUO_W-1:0]  s4_ll_r;
  logic [QUO_W-1:0]  s4_len_r;
  logic [QUO_W-1:0]  s4_vsq_r;
  logic [QUO_W-1:0]  s4_wsq_r;
  logic [DIFF_W-1:0] s4_line_r;
  logic [DIFF_W-1:0] s4_span_r;

  logic             dot_pos_c;
  logic             dot_gt_c;
  logic [QUO_W-1:0] dotm_c;
  psd_case_t        kase4_nxt;

  always_comb begin
    dot_pos_c = !s3_dot_r[DOT_W-1] && (s3_dot_r != '0);
    dot_gt_c  = dot_pos_c && (s3_dot_r[QUO_W:0] > {1'b0, s3_len_r});
    dotm_c    = s3_dot_r[QUO_W-1:0];
    case (s3_dim_r)
      2'd0:    kase4_nxt = K_INVALID;
      2'd1:    kase4_nxt = s3_kase_r;
      default: begin
        if (!dot_pos_c)    kase4_nxt = K_AT_START;
        else if (dot_gt_c) kase4_nxt = K_AT_END;
        else               kase4_nxt = K_INSIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s4_kase_r <= kase4_nxt;
    s4_dotm_r <= dotm_c;
    s4_hh_r   <= dotm_c[QUO_W-1:HALF_W] * dotm_c[QUO_W-1:HALF_W];
    s4_hl_r   <= dotm_c[QUO_W-1:HALF_W] * dotm_c[HALF_W-1:0];
    s4_ll_r   <= dotm_c[HALF_W-1:0] * dotm_c[HALF_W-1:0];
    s4_len_r  <= s3_len_r;
    s4_vsq_r  <= s3_vsq_r;
    s4_wsq_r  <= s3_wsq_r;
    s4_line_r <= s3_line_r;
    s4_span_r <= s3_span_r;
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
  end

  // ---- stage 5: divider operands
  localparam int PAR_SHIFT = PAR_W - 1;

  logic        s5_vld_r;
  psd_div_op_t s5_op_r;
  psd_div_op_t op_nxt;

  always_comb begin
    op_nxt.num_b = {s4_hh_r, {QUO_W{1'b0}}}
                 + NUM_W'({s4_hl_r, {(HALF_W + 1){1'b0}}})
                 + NUM_W'(s4_ll_r);
    op_nxt.den_b = s4_len_r;
    if (s4_kase_r == K_LINE) begin
      op_nxt.num_a = NUM_W'({s4_line_r, {PAR_SHIFT{1'b0}}});
      op_nxt.den_a = QUO_W'(s4_span_r);
    end else begin
      op_nxt.num_a = NUM_W'({s4_dotm_r, {PAR_SHIFT{1'b0}}});
      op_nxt.den_a = s4_len_r;
    end
    op_nxt.side.kase   = s4_kase_r;
    op_nxt.side.v_sq   = s4_vsq_r;
    op_nxt.side.w_sq   = s4_wsq_r;
    op_nxt.side.len_sq = s4_len_r;
  end

  always_ff @(posedge clk) begin
    s5_op_r <= op_nxt;
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
  end

  // ---- divider: lane a gives the parameter, lane b dot^2/len
  logic         dv_vld;
  psd_div_res_t dv_res;

  psd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s5_vld_r),
    .in_op   (s5_op_r),
    .out_vld (dv_vld),
    .out_res (dv_res)
  );

  // ---- output register: select fields by case
  logic     out_valid_r;
  psd_out_t out_item_r;
  psd_out_t out_nxt;

  always_comb begin
    out_nxt.status        = 1'b0;
    out_nxt.distance_sq   = '0;
    out_nxt.param         = '0;
    out_nxt.length_sq     = SQ_W'(dv_res.side.len_sq);
    out_nxt.from_start_sq = '0;
    case (dv_res.side.kase)
      K_INVALID: begin
        out_nxt.status    = 1'b1;
        out_nxt.length_sq = '0;
      end
      K_AT_START: begin
        out_nxt.distance_sq = SQ_W'(dv_res.side.v_sq);
      end
      K_AT_END: begin
        out_nxt.distance_sq   = SQ_W'(dv_res.side.w_sq);
        out_nxt.param         = PARAM_ONE;
        out_nxt.from_start_sq = SQ_W'(dv_res.side.len_sq);
      end
      K_LOW_REV: begin
        out_nxt.distance_sq   = SQ_W'(dv_res.side.w_sq);
        out_nxt.from_start_sq = SQ_W'(dv_res.side.len_sq);
      end
      K_HIGH_REV: begin
        out_nxt.distance_sq = SQ_W'(dv_res.side.v_sq);
        out_nxt.param       = PARAM_ONE;
      end
      K_ZERO: begin
        out_nxt.distance_sq = '0;
      end
      K_LINE: begin
        out_nxt.param         = dv_res.q_a[PAR_W-1:0];
        out_nxt.from_start_sq = SQ_W'(dv_res.side.v_sq);
      end
      K_INSIDE: begin
        // round the subtracted quotient up when it left a remainder
        out_nxt.distance_sq   = SQ_W'(dv_res.side.v_sq - dv_res.q_b
                                      - QUO_W'(dv_res.rem_b_nz));
        out_nxt.param         = dv_res.q_a[PAR_W-1:0];
        out_nxt.from_start_sq = SQ_W'(dv_res.q_b);
      end
      default: begin
        out_nxt.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_vld;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  localparam int LATENCY = DIV_STAGES + 6;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result beat without a matching start");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |->
      out_item.distance_sq == '0 && out_item.param == '0 &&
      out_item.length_sq == '0 && out_item.from_start_sq == '0)
    else $error("invalid result carries non-zero fields");

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.status |-> out_item.param <= PARAM_ONE)
    else $error("parameter beyond segment end");
`endif

endmodule

// ===== tb/point_segment_distance_sq_tb.sv =====
// Self-checking testbench for the point-to-segment squared distance pipeline.
module point_segment_distance_sq_tb;
  import psd_pkg::*;

  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;
  localparam logic [127:0] SQ_SAT = 128'd4503599627370495;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 80;

  typedef struct {
    psd_in_t item;
    bit      drain;   // hold off until every expected result has come back
  } query_t;

  logic     clk;
  logic     rst_n;
  logic     start = 1'b0;
  logic     busy;
  psd_in_t  in_item = '0;
  logic     out_valid;
  psd_out_t out_item;

  query_t   pending_queries[$];
  psd_out_t expected_results[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       gap_left = 0;
  bit       beat_taken = 1'b0;

  point_segment_distance_sq dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sext(logic [COORD_BITS-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [127:0] mag(longint v);
    logic [127:0] w;
    w = 128'(unsigned'(v < 0 ? -v : v));
    return w;
  endfunction

  function automatic logic [127:0] sq_of(longint v);
    return mag(v) * mag(v);
  endfunction

  function automatic logic [SQ_W-1:0] clamp_sq(logic [127:0] v);
    return (v > SQ_SAT) ? SQ_SAT[SQ_W-1:0] : v[SQ_W-1:0];
  endfunction

  function automatic logic [PAR_W-1:0] clamp_param(logic [127:0] v);
    return (v > 128'd65536) ? PARAM_ONE : v[PAR_W-1:0];
  endfunction

  // Work out the squared distance result of one query.
  function automatic psd_out_t segment_distance(psd_in_t q);
    psd_out_t     r;
    longint       a[3], b[3], p[3], s[3], v[3], c[3];
    longint       lo, hi, dot;
    logic [127:0] len, dst, par, fs, cs;
    bit           rev;
    r = '0;
    if (q.dimension == 2'd0) begin
      r.status = 1'b1;
      return r;
    end
    a[0] = sext(q.start_x); b[0] = sext(q.end_x); p[0] = sext(q.point_x);
    a[1] = sext(q.start_y); b[1] = sext(q.end_y); p[1] = sext(q.point_y);
    a[2] = sext(q.start_z); b[2] = sext(q.end_z); p[2] = sext(q.point_z);
    for (int k = 0; k < 3; k++) begin
      if (k >= q.dimension) begin
        a[k] = 0; b[k] = 0; p[k] = 0;
      end
    end
    len = 0; dst = 0; par = 0; fs = 0;
    if (q.dimension == 2'd1) begin
      rev = a[0] > b[0];
      lo  = rev ? b[0] : a[0];
      hi  = rev ? a[0] : b[0];
      len = sq_of(hi - lo);
      if (p[0] < lo) begin
        fs = rev ? len : 0; dst = sq_of(lo - p[0]);
      end else if (p[0] > hi) begin
        par = 65536; fs = rev ? 0 : len; dst = sq_of(p[0] - hi);
      end else if (hi != lo) begin
        par = (mag(p[0] - lo) << 16) / mag(hi - lo);
        fs  = sq_of(p[0] - a[0]);
      end
    end else begin
      dot = 0;
      for (int k = 0; k < 3; k++) begin
        s[k] = b[k] - a[k];
        v[k] = p[k] - a[k];
        dot += s[k] * v[k];
        len += sq_of(s[k]);
      end
      if (dot <= 0) begin
        dst = sq_of(v[0]) + sq_of(v[1]) + sq_of(v[2]);
      end else if (mag(dot) > len) begin
        par = 65536; fs = len;
        dst = sq_of(p[0] - b[0]) + sq_of(p[1] - b[1]) + sq_of(p[2] - b[2]);
      end else begin
        par  = (mag(dot) << 16) / len;
        fs   = (mag(dot) * mag(dot)) / len;
        c[0] = v[1] * s[2] - v[2] * s[1];
        c[1] = v[2] * s[0] - v[0] * s[2];
        c[2] = v[0] * s[1] - v[1] * s[0];
        cs   = sq_of(c[0]) + sq_of(c[1]) + sq_of(c[2]);
        dst  = cs / len;
      end
    end
    r.distance_sq   = clamp_sq(dst);
    r.param         = clamp_param(par);
    r.length_sq     = clamp_sq(len);
    r.from_start_sq = clamp_sq(fs);
    return r;
  endfunction

  task automatic add_query(int dim, longint ax, longint ay, longint az,
                           longint bx, longint by, longint bz,
                           longint px, longint py, longint pz, bit drain);
    query_t e;
    e.item.dimension = dim[1:0];
    e.item.start_x = ax[COORD_BITS-1:0]; e.item.start_y = ay[COORD_BITS-1:0];
    e.item.start_z = az[COORD_BITS-1:0]; e.item.end_x   = bx[COORD_BITS-1:0];
    e.item.end_y   = by[COORD_BITS-1:0]; e.item.end_z   = bz[COORD_BITS-1:0];
    e.item.point_x = px[COORD_BITS-1:0]; e.item.point_y = py[COORD_BITS-1:0];
    e.item.point_z = pz[COORD_BITS-1:0];
    e.drain = drain;
    pending_queries.push_back(e);
  endtask

  function automatic longint clip(longint v);
    return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
  endfunction

  function automatic longint any_coord();
    case ($urandom_range(0, 3))
      0: return sext(COORD_BITS'($urandom));
      1: return longint'($urandom_range(0, 511)) - 256;
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return longint'($urandom_range(0, 2097151)) - 1048576;
    endcase
  endfunction

  // Random query; most put the point close to the segment line so every
  // projection region turns up, the rest are plain noise.
  task automatic add_random_query(bit drain);
    longint a[3], b[3], p[3];
    int     dim, t;
    dim = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
    for (int k = 0; k < 3; k++) begin
      a[k] = any_coord();
      b[k] = ($urandom_range(0, 9) == 0) ? a[k] : any_coord();
    end
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 3; k++) p[k] = any_coord();
    end else begin
      t = $urandom_range(0, 40) - 12;
      for (int k = 0; k < 3; k++)
        p[k] = clip(a[k] + (b[k] - a[k]) * t / 16
                    + longint'($urandom_range(0, 64)) - 32);
    end
    add_query(dim, a[0], a[1], a[2], b[0], b[1], b[2], p[0], p[1], p[2], drain);
  endtask

  // Driver: change inputs on the falling edge, draw an idle gap per beat.
  always @(negedge clk) begin
    if (beat_taken) begin
      void'(pending_queries.pop_front());
      gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
    end
    if (!rst_n || gap_left > 0 || pending_queries.size() == 0) begin
      if (rst_n && gap_left > 0) gap_left--;
      start <= 1'b0;
    end else if (pending_queries[0].drain && expected_results.size() != 0) begin
      start <= 1'b0;
    end else begin
      start   <= 1'b1;
      in_item <= pending_queries[0].item;
    end
  end

  // Monitor: accept beats and check results on the rising edge.
  always @(posedge clk) begin
    psd_out_t want;
    beat_taken <= 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status
              || out_item.distance_sq !== want.distance_sq
              || out_item.param !== want.param
              || out_item.length_sq !== want.length_sq
              || out_item.from_start_sq !== want.from_start_sq) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, out_item);
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(segment_distance(in_item));
        beat_taken <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;

    // Directed: invalid dimension, extremes, every projection region.
    add_query(0, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 0);
    add_query(1, CMIN, 0, 0, CMAX, 0, 0, CMAX, 0, 0, 0);
    add_query(1, CMAX, 0, 0, CMIN, 0, 0, CMIN, 0, 0, 0);
    add_query(1, 100, 0, 0, 500, 0, 0, 50, 0, 0, 0);
    add_query(1, 500, 0, 0, 100, 0, 0, 50, 0, 0, 0);
    add_query(1, 100, 0, 0, 500, 0, 0, 900, 0, 0, 0);
    add_query(1, 500, 0, 0, 100, 0, 0, 900, 0, 0, 0);
    add_query(1, 300, 0, 0, 300, 0, 0, 300, 0, 0, 0);
    add_query(1, 300, 0, 0, 300, 0, 0, 200, 0, 0, 0);
    add_query(1, 500, 0, 0, 100, 0, 0, 333, 0, 0, 0);
    add_query(2, 0, 0, 0, 0, 0, 0, 40, -40, 0, 0);
    add_query(2, 0, 0, 0, 1000, 0, 0, -5, 300, 0, 0);
    add_query(2, 0, 0, 0, 1000, 0, 0, 1005, 300, 0, 0);
    add_query(2, 0, 0, 0, 1000, 0, 0, 400, 300, 0, 0);
    add_query(2, 0, 0, 0, 1000, 0, 0, 1000, 77, 0, 0);
    add_query(2, CMIN, CMIN, 0, CMAX, CMAX, 0, CMAX, CMIN, 0, 0);
    add_query(3, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, 0);
    add_query(3, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 1);
    add_query(3, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
    add_query(3, 10, 20, 30, 10, 20, 30, CMAX, CMIN, CMAX, 0);
    add_query(3, 0, 0, 0, 256, 256, 256, 128, 128, 129, 0);
    add_query(3, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0);
    for (int i = 0; i < 1550; i++) add_random_query(i == 700 || i == 1200);

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    wait (pending_queries.size() == 0);
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
